// File: rtl/thermostat_hysteresis_controller_assert.svh
// ---------------------------------------------------------------------------
// Thermostat controller assertion macros
// Clocked, reset-qualified property wrappers for the controller checks.
// ---------------------------------------------------------------------------
`ifndef THERMOSTAT_HYSTERESIS_CONTROLLER_ASSERT_SVH
`define THERMOSTAT_HYSTERESIS_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define THC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define THC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/thc_pkg.sv
// ---------------------------------------------------------------------------
// Thermostat controller package
// Mode and register index codes, field widths and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

    localparam int TEMP_W  = 16;
    localparam int HUM_W   = 11;
    localparam int SP_W    = 7;
    localparam int BAND_W  = 10;
    localparam int CNT_W   = 16;
    localparam int CMP_W   = 17;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;

    localparam logic [CNT_W-1:0] BOOT_HOLD     = CNT_W'(45);
    localparam logic [SP_W-1:0]  RST_HEAT_SP   = SP_W'(68);
    localparam logic [SP_W-1:0]  RST_COOL_SP   = SP_W'(76);
    localparam logic [SP_W-1:0]  RST_HUM_SP    = SP_W'(50);
    localparam logic [BAND_W-1:0] RST_HALF_BAND = BAND_W'(8);

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_HEAT  = 2'd1,
        MODE_COOL  = 2'd2,
        MODE_DEHUM = 2'd3
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_FAN_MODE  = 3'd1,
        REG_HEAT_SP   = 3'd2,
        REG_COOL_SP   = 3'd3,
        REG_HUM_SP    = 3'd4,
        REG_HALF_BAND = 3'd5,
        REG_HOLD      = 3'd6,
        REG_MIN_RUN   = 3'd7
    } t_cfg_idx;

endpackage

`default_nettype wire

// File: rtl/thermostat_hysteresis_controller.sv
// ---------------------------------------------------------------------------
// Thermostat hysteresis controller
// One transaction per one-second tick: heat, cool and dehumidify on/off
// control with restart hold and minimum run countdowns.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries temperature (signed 12.4)
//   and humidity (unsigned 7.4) for one tick. Output channel (o_out_valid /
//   i_out_stall) returns one result transaction per tick: demand, relay
//   drives, wait flag and the restart hold seconds left.
//   From acceptance to o_out_valid the tick is captured in the input register
//   and then passes through the control logic into the result register once
//   that register is free to take it.
//   Throughput is one tick per cycle while the receiver does not stall; the
//   control state updates as each tick advances, so ticks follow back to back.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more tick; o_in_stall rises only when both are full.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while no tick is in flight; every index selects a register.
//   Synchronous reset restores register defaults, clears demand and wait,
//   loads the 45 second boot restart hold and empties both stages.
// ---------------------------------------------------------------------------
`default_nettype none

module thermostat_hysteresis_controller
    import thc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [TEMP_W-1:0] i_temperature,
    input  wire logic [HUM_W-1:0]         i_humidity,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_control_on,
    output logic                          o_drive_relay,
    output logic                          o_waiting,
    output logic                          o_fan_drive,
    output logic [CNT_W-1:0]              o_hold_remaining
);

    function automatic logic signed [CMP_W-1:0] f_upper(
        input logic [SP_W-1:0]   sp,
        input logic [BAND_W-1:0] hb
    );
        return $signed({{(CMP_W-SP_W-4){1'b0}}, sp, 4'b0000})
             + $signed({{(CMP_W-BAND_W){1'b0}}, hb});
    endfunction

    function automatic logic signed [CMP_W-1:0] f_lower(
        input logic [SP_W-1:0]   sp,
        input logic [BAND_W-1:0] hb
    );
        return $signed({{(CMP_W-SP_W-4){1'b0}}, sp, 4'b0000})
             - $signed({{(CMP_W-BAND_W){1'b0}}, hb});
    endfunction

    t_mode              r_mode;
    logic               r_fan_mode;
    logic [SP_W-1:0]    r_heat_sp;
    logic [SP_W-1:0]    r_cool_sp;
    logic [SP_W-1:0]    r_hum_sp;
    logic [BAND_W-1:0]  r_half_band;
    logic [CNT_W-1:0]   r_hold_reload;
    logic [CNT_W-1:0]   r_min_run;

    t_mode              r_prior_mode;
    logic               r_demand;
    logic               r_wait;
    logic [CNT_W-1:0]   r_hold_count;
    logic [CNT_W-1:0]   r_run_count;

    logic                     r_in_valid;
    logic signed [TEMP_W-1:0] r_in_temp;
    logic [HUM_W-1:0]         r_in_hum;

    logic               r_out_valid;
    logic               r_out_control;
    logic               r_out_drive;
    logic               r_out_wait;
    logic               r_out_fan;
    logic [CNT_W-1:0]   r_out_hold;

    logic               advance;
    logic               in_take;
    logic               wait_mode;
    logic signed [CMP_W-1:0] temp_x;
    logic signed [CMP_W-1:0] hum_x;
    logic signed [CMP_W-1:0] heat_hi, heat_lo, cool_hi, cool_lo, hum_hi, hum_lo;
    logic               dem0;
    logic               n_demand;
    logic               n_wait;
    logic [CNT_W-1:0]   hold_mid;
    logic [CNT_W-1:0]   run_mid;
    logic [CNT_W-1:0]   n_hold_count;
    logic [CNT_W-1:0]   n_run_count;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign wait_mode   = (r_mode == MODE_COOL) || (r_mode == MODE_DEHUM);

    assign temp_x  = CMP_W'(r_in_temp);
    assign hum_x   = $signed({{(CMP_W-HUM_W){1'b0}}, r_in_hum});
    assign heat_hi = f_upper(r_heat_sp, r_half_band);
    assign heat_lo = f_lower(r_heat_sp, r_half_band);
    assign cool_hi = f_upper(r_cool_sp, r_half_band);
    assign cool_lo = f_lower(r_cool_sp, r_half_band);
    assign hum_hi  = f_upper(r_hum_sp, r_half_band);
    assign hum_lo  = f_lower(r_hum_sp, r_half_band);

    assign dem0 = (r_prior_mode != r_mode) ? 1'b0 : r_demand;

    always_comb begin
        n_demand = dem0;
        n_wait   = r_wait;
        hold_mid = r_hold_count;
        run_mid  = r_run_count;
        unique case (r_mode)
            MODE_HEAT: begin
                if (dem0 && temp_x > heat_hi) begin
                    n_demand = 1'b0;
                end else if (!dem0 && temp_x < heat_lo) begin
                    n_demand = 1'b1;
                end
            end
            MODE_COOL: begin
                if (dem0 && temp_x < cool_lo) begin
                    n_demand = 1'b0;
                    hold_mid = r_hold_reload;
                end else if (!dem0 && temp_x > cool_hi) begin
                    n_wait = (r_hold_count != '0);
                    if (r_hold_count == '0) begin
                        n_demand = 1'b1;
                    end
                end else begin
                    n_wait = 1'b0;
                end
            end
            MODE_DEHUM: begin
                if (dem0 && hum_x < hum_lo) begin
                    n_wait = (r_run_count != '0);
                    if (r_run_count == '0) begin
                        n_demand = 1'b0;
                        hold_mid = r_hold_reload;
                    end
                end else if (!dem0 && hum_x > hum_hi) begin
                    n_wait = (r_hold_count != '0);
                    if (r_hold_count == '0) begin
                        n_demand = 1'b1;
                        run_mid  = r_min_run;
                    end
                end else begin
                    n_wait = 1'b0;
                end
            end
            MODE_OFF: begin
                n_demand = dem0;
            end
        endcase
        n_hold_count = (hold_mid != '0) ? hold_mid - CNT_W'(1) : '0;
        n_run_count  = (run_mid != '0) ? run_mid - CNT_W'(1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OFF;
            r_fan_mode    <= 1'b0;
            r_heat_sp     <= RST_HEAT_SP;
            r_cool_sp     <= RST_COOL_SP;
            r_hum_sp      <= RST_HUM_SP;
            r_half_band   <= RST_HALF_BAND;
            r_hold_reload <= BOOT_HOLD;
            r_min_run     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_MODE:      r_mode        <= t_mode'(i_cfg_data[1:0]);
                REG_FAN_MODE:  r_fan_mode    <= i_cfg_data[0];
                REG_HEAT_SP:   r_heat_sp     <= i_cfg_data[SP_W-1:0];
                REG_COOL_SP:   r_cool_sp     <= i_cfg_data[SP_W-1:0];
                REG_HUM_SP:    r_hum_sp      <= i_cfg_data[SP_W-1:0];
                REG_HALF_BAND: r_half_band   <= i_cfg_data[BAND_W-1:0];
                REG_HOLD:      r_hold_reload <= i_cfg_data[CNT_W-1:0];
                REG_MIN_RUN:   r_min_run     <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_mode <= MODE_OFF;
            r_demand     <= 1'b0;
            r_wait       <= 1'b0;
            r_hold_count <= BOOT_HOLD;
            r_run_count  <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_prior_mode <= r_mode;
                r_demand     <= n_demand;
                r_wait       <= n_wait;
                r_hold_count <= n_hold_count;
                r_run_count  <= n_run_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_temp <= i_temperature;
            r_in_hum  <= i_humidity;
        end
        if (advance) begin
            r_out_control <= n_demand;
            r_out_drive   <= (r_mode != MODE_OFF) && n_demand;
            r_out_wait    <= n_wait;
            r_out_fan     <= !r_fan_mode;
            r_out_hold    <= n_hold_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_control_on     = r_out_control;
    assign o_drive_relay    = r_out_drive;
    assign o_waiting        = r_out_wait;
    assign o_fan_drive      = r_out_fan;
    assign o_hold_remaining = r_out_hold;

`include "thermostat_hysteresis_controller_assert.svh"

    `THC_ASSERT_NEXT(a_fill_out, advance, r_out_valid, "pending tick did not reach result")
    `THC_ASSERT_NOW(a_relay_demand, r_out_valid && r_out_drive, r_out_control, "relay without demand")
    `THC_ASSERT_NOW(a_wait_mode, $rose(r_wait), $past(wait_mode), "wait outside cool or dehumidify")

endmodule

`default_nettype wire

// File: sim/thc_tick_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Thermostat controller tick checker
// Follows register writes and accepted input ticks, works out each tick's
// result from its own copy of the control state and compares every accepted
// result transaction with the oldest outstanding one, field by field.
// ---------------------------------------------------------------------------
module thc_tick_checker
    import thc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic [HUM_W-1:0]         i_humidity,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic                     i_control_on,
    input  logic                     i_drive_relay,
    input  logic                     i_waiting,
    input  logic                     i_fan_drive,
    input  logic [CNT_W-1:0]         i_hold_remaining,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic             control_on;
        logic             drive_relay;
        logic             waiting;
        logic             fan_drive;
        logic [CNT_W-1:0] hold_remaining;
    } t_tick_result;

    t_tick_result      expected_ticks[$];

    t_mode             mode_reg;
    t_mode             last_mode;
    logic              fan_setting;
    logic [SP_W-1:0]   heat_sp;
    logic [SP_W-1:0]   cool_sp;
    logic [SP_W-1:0]   hum_sp;
    logic [BAND_W-1:0] band;
    logic [CNT_W-1:0]  hold_reload;
    logic [CNT_W-1:0]  run_reload;
    logic [CNT_W-1:0]  hold_left;
    logic [CNT_W-1:0]  run_left;
    logic              demand;
    logic              wait_flag;
    int                fails = 0;

    function automatic int upper_edge(input logic [SP_W-1:0] sp);
        return int'(sp) * 16 + int'(band);
    endfunction

    function automatic int lower_edge(input logic [SP_W-1:0] sp);
        return int'(sp) * 16 - int'(band);
    endfunction

    function automatic t_tick_result advance_controller(input int temp, input int hum);
        t_tick_result res;
        if (last_mode != mode_reg) begin
            demand    = 1'b0;
            last_mode = mode_reg;
        end
        case (mode_reg)
            MODE_HEAT: begin
                if (demand && temp > upper_edge(heat_sp))
                    demand = 1'b0;
                else if (!demand && temp < lower_edge(heat_sp))
                    demand = 1'b1;
            end
            MODE_COOL: begin
                if (demand && temp < lower_edge(cool_sp)) begin
                    demand    = 1'b0;
                    hold_left = hold_reload;
                end else if (!demand && temp > upper_edge(cool_sp)) begin
                    wait_flag = (hold_left != '0);
                    if (!wait_flag)
                        demand = 1'b1;
                end else begin
                    wait_flag = 1'b0;
                end
            end
            MODE_DEHUM: begin
                if (demand && hum < lower_edge(hum_sp)) begin
                    wait_flag = (run_left != '0);
                    if (!wait_flag) begin
                        demand    = 1'b0;
                        hold_left = hold_reload;
                    end
                end else if (!demand && hum > upper_edge(hum_sp)) begin
                    wait_flag = (hold_left != '0);
                    if (!wait_flag) begin
                        demand   = 1'b1;
                        run_left = run_reload;
                    end
                end else begin
                    wait_flag = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (hold_left != '0)
            hold_left = hold_left - CNT_W'(1);
        if (run_left != '0)
            run_left = run_left - CNT_W'(1);
        res.control_on     = demand;
        res.drive_relay    = (mode_reg != MODE_OFF) && demand;
        res.waiting        = wait_flag;
        res.fan_drive      = !fan_setting;
        res.hold_remaining = hold_left;
        return res;
    endfunction

    function automatic int field_differs(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_tick_result want;
        if (!i_rst_n) begin
            mode_reg    = MODE_OFF;
            last_mode   = MODE_OFF;
            fan_setting = 1'b0;
            heat_sp     = RST_HEAT_SP;
            cool_sp     = RST_COOL_SP;
            hum_sp      = RST_HUM_SP;
            band        = RST_HALF_BAND;
            hold_reload = BOOT_HOLD;
            run_reload  = '0;
            hold_left   = BOOT_HOLD;
            run_left    = '0;
            demand      = 1'b0;
            wait_flag   = 1'b0;
            expected_ticks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_ticks.size() == 0) begin
                    $error("result transaction with no tick outstanding");
                    fails++;
                end else begin
                    want = expected_ticks.pop_front();
                    fails += field_differs("control_on", want.control_on, i_control_on);
                    fails += field_differs("drive_relay", want.drive_relay, i_drive_relay);
                    fails += field_differs("waiting", want.waiting, i_waiting);
                    fails += field_differs("fan_drive", want.fan_drive, i_fan_drive);
                    fails += field_differs("hold_remaining", want.hold_remaining,
                                           i_hold_remaining);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_ticks.push_back(advance_controller(int'(i_temperature),
                                                            int'(i_humidity)));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:      mode_reg    = t_mode'(i_cfg_data[1:0]);
                    REG_FAN_MODE:  fan_setting = i_cfg_data[0];
                    REG_HEAT_SP:   heat_sp     = i_cfg_data[SP_W-1:0];
                    REG_COOL_SP:   cool_sp     = i_cfg_data[SP_W-1:0];
                    REG_HUM_SP:    hum_sp      = i_cfg_data[SP_W-1:0];
                    REG_HALF_BAND: band        = i_cfg_data[BAND_W-1:0];
                    REG_HOLD:      hold_reload = i_cfg_data[CNT_W-1:0];
                    REG_MIN_RUN:   run_reload  = i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_ticks.size();
    end

endmodule

// File: sim/tb_thermostat_hysteresis_controller.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Thermostat hysteresis controller testbench
// Drives directed ticks through every mode, then random phases of ticks
// aimed around the switching thresholds under varied register settings,
// with random gaps and receiver stalls; a tick checker scores every result.
// ---------------------------------------------------------------------------
module tb_thermostat_hysteresis_controller;
    import thc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 46;
    localparam int STYLE_MIXED   = 0;
    localparam int STYLE_LOW     = 1;
    localparam int STYLE_HIGH    = 2;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [IDX_W-1:0]         i_cfg_index   = '0;
    logic [CFG_W-1:0]         i_cfg_data    = '0;
    logic                     i_in_valid    = 1'b0;
    logic signed [TEMP_W-1:0] i_temperature = '0;
    logic [HUM_W-1:0]         i_humidity    = '0;
    logic                     i_out_stall   = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic                     o_control_on;
    logic                     o_drive_relay;
    logic                     o_waiting;
    logic                     o_fan_drive;
    logic [CNT_W-1:0]         o_hold_remaining;

    int    fail_count;
    int    pending_ticks;
    int    cycle_count = 0;
    bit    steady      = 1'b0;
    t_mode mode_now    = MODE_OFF;
    int    heat_sp_now = int'(RST_HEAT_SP);
    int    cool_sp_now = int'(RST_COOL_SP);
    int    hum_sp_now  = int'(RST_HUM_SP);
    int    band_now    = int'(RST_HALF_BAND);

    always #10 i_clk = ~i_clk;

    thermostat_hysteresis_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_temperature    (i_temperature),
        .i_humidity       (i_humidity),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_control_on     (o_control_on),
        .o_drive_relay    (o_drive_relay),
        .o_waiting        (o_waiting),
        .o_fan_drive      (o_fan_drive),
        .o_hold_remaining (o_hold_remaining)
    );

    thc_tick_checker tick_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_temperature    (i_temperature),
        .i_humidity       (i_humidity),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_control_on     (o_control_on),
        .i_drive_relay    (o_drive_relay),
        .i_waiting        (o_waiting),
        .i_fan_drive      (o_fan_drive),
        .i_hold_remaining (o_hold_remaining),
        .o_fail_count     (fail_count),
        .o_pending        (pending_ticks)
    );

    task automatic send_tick(input logic signed [TEMP_W-1:0] temp,
                             input logic [HUM_W-1:0] hum);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_temperature <= temp;
        i_humidity    <= hum;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drain every outstanding result before touching the registers
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_ticks != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_MODE:      mode_now    = t_mode'(2'(value));
            REG_HEAT_SP:   heat_sp_now = value;
            REG_COOL_SP:   cool_sp_now = value;
            REG_HUM_SP:    hum_sp_now  = value;
            REG_HALF_BAND: band_now    = value;
            default: begin
            end
        endcase
    endtask

    function automatic int pick_setpoint();
        int choice;
        choice = $urandom_range(0, 9);
        if (choice == 0)
            return 0;
        if (choice == 1)
            return 99;
        return $urandom_range(0, 99);
    endfunction

    function automatic int pick_band();
        int choice;
        choice = $urandom_range(0, 9);
        if (choice == 0)
            return 0;
        if (choice == 1)
            return 1023;
        if (choice < 4)
            return $urandom_range(0, 1023);
        return $urandom_range(0, 40);
    endfunction

    function automatic logic signed [TEMP_W-1:0] pick_temperature();
        int centre;
        int reach;
        int choice;
        centre = ((mode_now == MODE_COOL) ? cool_sp_now : heat_sp_now) * 16;
        reach  = band_now + 24;
        choice = $urandom_range(0, 19);
        if (choice == 0)
            return {1'b0, {(TEMP_W-1){1'b1}}};
        if (choice == 1)
            return {1'b1, {(TEMP_W-1){1'b0}}};
        if (choice < 5)
            return TEMP_W'($urandom);
        return TEMP_W'(centre - reach + int'($urandom_range(0, 2 * reach)));
    endfunction

    function automatic logic [HUM_W-1:0] pick_humidity();
        int aim;
        int reach;
        int choice;
        reach  = band_now + 24;
        choice = $urandom_range(0, 19);
        if (choice == 0)
            return '1;
        if (choice == 1)
            return '0;
        if (choice < 5)
            return HUM_W'($urandom);
        aim = hum_sp_now * 16 - reach + int'($urandom_range(0, 2 * reach));
        if (aim < 0)
            aim = 0;
        if (aim > 2047)
            aim = 2047;
        return HUM_W'(aim);
    endfunction

    task automatic random_phase(input int style);
        int items;
        settle();
        steady = ($urandom_range(0, 3) == 0);
        write_reg(REG_MODE, $urandom_range(0, 3));
        if (style == STYLE_LOW) begin
            write_reg(REG_FAN_MODE, 1);
            write_reg(REG_HEAT_SP, 0);
            write_reg(REG_COOL_SP, 0);
            write_reg(REG_HUM_SP, 0);
            write_reg(REG_HALF_BAND, 0);
            write_reg(REG_HOLD, 0);
            write_reg(REG_MIN_RUN, 0);
        end else if (style == STYLE_HIGH) begin
            write_reg(REG_FAN_MODE, 0);
            write_reg(REG_HEAT_SP, 99);
            write_reg(REG_COOL_SP, 99);
            write_reg(REG_HUM_SP, 99);
            write_reg(REG_HALF_BAND, 1023);
            write_reg(REG_HOLD, 65535);
            write_reg(REG_MIN_RUN, 65535);
        end else begin
            if ($urandom_range(0, 1))
                write_reg(REG_FAN_MODE, $urandom_range(0, 1));
            if ($urandom_range(0, 1))
                write_reg(REG_HEAT_SP, pick_setpoint());
            if ($urandom_range(0, 1))
                write_reg(REG_COOL_SP, pick_setpoint());
            if ($urandom_range(0, 1))
                write_reg(REG_HUM_SP, pick_setpoint());
            if ($urandom_range(0, 1))
                write_reg(REG_HALF_BAND, pick_band());
            if ($urandom_range(0, 1))
                write_reg(REG_HOLD, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 40));
            if ($urandom_range(0, 1))
                write_reg(REG_MIN_RUN, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
        end
        items = $urandom_range(30, 50);
        repeat (items) send_tick(pick_temperature(), pick_humidity());
    endtask

    initial begin
        int unsigned hold_off;
        forever begin
            hold_off = steady ? 0 : $urandom_range(0, 8);
            if (hold_off != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int heat_ref;
        int cool_ref;
        int hum_ref;
        heat_ref = int'(RST_HEAT_SP) * 16;
        cool_ref = int'(RST_COOL_SP) * 16;
        hum_ref  = int'(RST_HUM_SP) * 16;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // off mode: relay held low whatever the sensors say
        send_tick(16'sh7FFF, 11'h7FF);
        send_tick(16'sh8000, 11'h000);

        settle();
        write_reg(REG_MODE, MODE_HEAT);
        send_tick(TEMP_W'(0), 11'h000);
        send_tick(TEMP_W'(heat_ref), 11'h400);
        send_tick(TEMP_W'(heat_ref + 9), 11'h400);
        send_tick(TEMP_W'(heat_ref + 8), 11'h400);
        send_tick(TEMP_W'(heat_ref - 9), 11'h400);
        send_tick(TEMP_W'(heat_ref - 8), 11'h400);

        // cool start blocked by the boot hold, then cleared inside the band
        settle();
        write_reg(REG_MODE, MODE_COOL);
        write_reg(REG_FAN_MODE, 1);
        send_tick(16'sh7FFF, 11'h000);
        send_tick(TEMP_W'(cool_ref), 11'h000);
        send_tick(TEMP_W'(cool_ref + 9), 11'h000);

        settle();
        write_reg(REG_MIN_RUN, 2);
        write_reg(REG_HOLD, 3);
        write_reg(REG_MODE, MODE_DEHUM);
        send_tick(16'sh0000, 11'h7FF);
        send_tick(16'sh0000, HUM_W'(hum_ref));
        send_tick(16'sh0000, HUM_W'(hum_ref - 9));
        send_tick(16'sh0000, HUM_W'(hum_ref + 9));

        settle();
        write_reg(REG_MODE, MODE_OFF);
        send_tick(16'sh8000, 11'h7FF);
        send_tick(16'sh7FFF, 11'h000);

        random_phase(STYLE_LOW);
        for (int phase = 1; phase < RANDOM_PHASES - 1; phase++)
            random_phase(STYLE_MIXED);
        random_phase(STYLE_HIGH);

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
